/* hdl/mrrv_pkg.sv */
// Package: item kinds, verdict codes, register indexes and the Modbus CRC-16 byte update.
`default_nettype none
package mrrv_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_IDLE   = 2'd1,
        KIND_ARM    = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        V_REJECT    = 3'd0,
        V_CRC_GOOD  = 3'd1,
        V_CRC_BAD   = 3'd2,
        V_EXCEPTION = 3'd3,
        V_HELD      = 3'd4
    } t_verdict;

    localparam logic [0:0] REG_SLAVE_ADDRESS    = 1'b0;
    localparam logic [0:0] REG_REQUEST_FUNCTION = 1'b1;

    localparam logic [7:0] SLAVE_ADDRESS_RESET    = 8'h01;
    localparam logic [7:0] REQUEST_FUNCTION_RESET = 8'h03;

    localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
    localparam logic [7:0] FC_WRITE_REG   = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS = 8'h0f;
    localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
    localparam logic [7:0] FC_READ_FIRST  = 8'h01;
    localparam logic [7:0] FC_READ_LAST   = 8'h04;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One byte through the reflected CRC-16, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/modbus_rtu_response_validator.sv */
// A result is registered after the idle transaction that causes it
// (input register, then evaluation into the output register).
// Throughput: one transaction per cycle while the input is not stalled; the byte-wide CRC update is combinational.
// Input stalls only when an idle event meets an output register that is not taken.
// Reset (synchronous, active low) clears the frame state and held flag, sets
// slave_address to 1 and request_function to 3, and empties both registers.
`default_nettype none
module modbus_rtu_response_validator import mrrv_pkg::*; #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire  [1:0]  i_s_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] function_code, [16:8] frame_length,
                                          // [24:17] exception_code, [31:25] zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] verdict
);

    localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

    logic [7:0]  r_slave_address;
    logic [7:0]  r_request_function;

    logic        r_in_valid;
    t_kind       r_in_kind;
    logic [7:0]  r_in_byte;

    logic [CW-1:0] r_count,   n_count;
    logic [7:0]    r_fb0,     n_fb0;
    logic [7:0]    r_fb1,     n_fb1;
    logic [7:0]    r_fb2,     n_fb2;
    logic [15:0]   r_crc,     n_crc;
    logic [7:0]    r_dly0,    n_dly0;
    logic [7:0]    r_dly1,    n_dly1;
    logic          r_held,    n_held;

    logic          r_out_valid;
    t_verdict      r_verdict, n_verdict;
    logic [7:0]    r_out_fc;
    logic [8:0]    r_out_len;
    logic [7:0]    r_out_exc, n_out_exc;

    logic advance;
    logic load_out;
    logic full;
    logic addr_ok;
    logic is_read;
    logic is_write;
    logic is_exc;
    logic accept;

    assign load_out = r_in_valid && (r_in_kind == KIND_IDLE);
    // An idle item waits only if the output register is occupied and not taken.
    assign advance  = r_in_valid && (!load_out || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address    <= SLAVE_ADDRESS_RESET;
            r_request_function <= REQUEST_FUNCTION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SLAVE_ADDRESS:    r_slave_address    <= i_cfg_wdata;
                REG_REQUEST_FUNCTION: r_request_function <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind <= t_kind'(i_s_axis_tuser);
            r_in_byte <= i_s_axis_tdata;
        end
    end

    assign full     = (r_count == CW'(RX_BUFFER_BYTES));
    assign addr_ok  = (r_fb0 == r_slave_address);
    assign is_read  = (r_fb1 >= FC_READ_FIRST) && (r_fb1 <= FC_READ_LAST);
    assign is_write = (r_fb1 == FC_WRITE_COIL) || (r_fb1 == FC_WRITE_REG) ||
                      (r_fb1 == FC_WRITE_COILS) || (r_fb1 == FC_WRITE_REGS);
    // 0x80 plus the request code at nine bits: no match for codes from 0x80 up.
    assign is_exc   = r_fb1[7] && !r_request_function[7] &&
                      (r_fb1[6:0] == r_request_function[6:0]);

    always_comb begin
        accept = 1'b0;
        if (addr_ok) begin
            if (is_read) begin
                accept = (10'(r_count) == ({2'b00, r_fb2} + 10'd5));
            end else if (is_write) begin
                accept = (10'(r_count) == 10'd8);
            end else if (is_exc) begin
                accept = (10'(r_count) >= 10'd3);
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_fb0     = r_fb0;
        n_fb1     = r_fb1;
        n_fb2     = r_fb2;
        n_crc     = r_crc;
        n_dly0    = r_dly0;
        n_dly1    = r_dly1;
        n_held    = r_held;
        n_verdict = V_REJECT;
        n_out_exc = 8'h00;
        if (advance) begin
            case (r_in_kind)
                KIND_BYTE: begin
                    if (!r_held && !full) begin
                        if (r_count < CW'(3)) begin
                            case (r_count[1:0])
                                2'd0:    n_fb0 = r_in_byte;
                                2'd1:    n_fb1 = r_in_byte;
                                default: n_fb2 = r_in_byte;
                            endcase
                        end
                        if (r_count >= CW'(2)) begin
                            n_crc = crc16_byte(r_crc, r_dly0);
                        end
                        n_dly0  = r_dly1;
                        n_dly1  = r_in_byte;
                        n_count = r_count + CW'(1);
                    end
                end
                KIND_ARM: begin
                    n_count = '0;
                    n_fb0   = 8'h00;
                    n_fb1   = 8'h00;
                    n_fb2   = 8'h00;
                    n_crc   = CRC_INIT;
                    n_dly0  = 8'h00;
                    n_dly1  = 8'h00;
                    n_held  = 1'b0;
                end
                KIND_IDLE: begin
                    if (r_held) begin
                        n_verdict = V_HELD;
                    end else if (!accept) begin
                        n_verdict = V_REJECT;
                        n_count   = '0;
                        n_fb0     = 8'h00;
                        n_fb1     = 8'h00;
                        n_fb2     = 8'h00;
                        n_crc     = CRC_INIT;
                        n_dly0    = 8'h00;
                        n_dly1    = 8'h00;
                    end else begin
                        n_held = 1'b1;
                        if (is_exc && !is_read && !is_write) begin
                            n_verdict = V_EXCEPTION;
                            n_out_exc = r_fb2;
                        end else if (r_crc == {r_dly1, r_dly0}) begin
                            n_verdict = V_CRC_GOOD;
                        end else begin
                            n_verdict = V_CRC_BAD;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fb0   <= 8'h00;
            r_fb1   <= 8'h00;
            r_fb2   <= 8'h00;
            r_crc   <= CRC_INIT;
            r_dly0  <= 8'h00;
            r_dly1  <= 8'h00;
            r_held  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_fb0   <= n_fb0;
            r_fb1   <= n_fb1;
            r_fb2   <= n_fb2;
            r_crc   <= n_crc;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload is taken from the state before this idle event updates it.
    always_ff @(posedge i_clk) begin
        if (advance && load_out) begin
            r_verdict <= n_verdict;
            r_out_fc  <= r_fb1;
            r_out_len <= 9'(r_count);
            r_out_exc <= n_out_exc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_verdict;
    assign o_m_axis_tdata  = {7'b0, r_out_exc, r_out_len, r_out_fc};

endmodule
`default_nettype wire

/* hdl/mrrv_checker.sv */
// Port-level checker for the response validator, with its bind statement.
`default_nettype none
module mrrv_checker import mrrv_pkg::*; #(
    parameter int RX_BUFFER_BYTES = 256
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [31:0] o_m_axis_tdata,
    input wire [2:0]  o_m_axis_tuser
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[16:8] <= 9'(RX_BUFFER_BYTES)))
        else $error("frame length beyond buffer size");

    a_exc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != V_EXCEPTION) |-> (o_m_axis_tdata[24:17] == 8'h00))
        else $error("exception code set on a non-exception verdict");

    a_exc_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == V_EXCEPTION) |-> o_m_axis_tdata[7])
        else $error("exception verdict without exception function code");

endmodule

bind modbus_rtu_response_validator mrrv_checker #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
) u_mrrv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
